### hdl/rbb3_pkg.sv
// shared constants and types for the rgb 3x3 box blur
`timescale 1ns / 1ps

package rbb3_pkg;

    // parameter defaults
    localparam int MAX_LINE_LENGTH_DEF = 1024;
    localparam int PIXEL_BITS_DEF      = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd600;
    localparam logic [CNT_W-1:0] CNT_RESET = 16'd800;

    // result field widths
    localparam int MEAN_W   = 16;
    localparam int CLINE_W  = 16;
    localparam int CCOL_W   = 10;

    // position tag that travels with a request down the pipe
    typedef struct packed {
        logic [CLINE_W-1:0] center_line;
        logic [CCOL_W-1:0]  center_column;
        logic               frame_end;
    } t_tag;

endpackage

### hdl/rbb3_pix_if.sv
// pixel input channel
`timescale 1ns / 1ps

interface rbb3_pix_if #(
    parameter int PIXEL_BITS = rbb3_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] red_in;
    logic [PIXEL_BITS-1:0] green_in;
    logic [PIXEL_BITS-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

### hdl/rbb3_mean_if.sv
// mean result channel
`timescale 1ns / 1ps

interface rbb3_mean_if;
    logic                           valid;
    logic                           ready;
    logic [rbb3_pkg::MEAN_W-1:0]    red_mean;
    logic [rbb3_pkg::MEAN_W-1:0]    green_mean;
    logic [rbb3_pkg::MEAN_W-1:0]    blue_mean;
    logic [rbb3_pkg::CLINE_W-1:0]   center_line;
    logic [rbb3_pkg::CCOL_W-1:0]    center_column;
    logic                           frame_end;

    modport source (output valid, red_mean, green_mean, blue_mean, center_line,
                    center_column, frame_end, input ready);
    modport sink   (input valid, red_mean, green_mean, blue_mean, center_line,
                    center_column, frame_end, output ready);
endinterface

### hdl/rbb3_line_ram.sv
// simple dual port line store with registered read
`timescale 1ns / 1ps

module rbb3_line_ram #(
    parameter int DEPTH = rbb3_pkg::MAX_LINE_LENGTH_DEF,
    parameter int WIDTH = 6 * rbb3_pkg::PIXEL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rbb3_window.sv
// two column window and per channel 3x3 sum stage
`timescale 1ns / 1ps

module rbb3_window #(
    parameter int PIXEL_BITS = rbb3_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic                        i_prod,
    input  rbb3_pkg::t_tag              i_tag,
    input  logic [2:0][PIXEL_BITS-1:0]  i_top,
    input  logic [2:0][PIXEL_BITS-1:0]  i_mid,
    input  logic [2:0][PIXEL_BITS-1:0]  i_bot,
    output logic                        o_valid,
    output logic [2:0][PIXEL_BITS+3:0]  o_sum,
    output rbb3_pkg::t_tag              o_tag
);

    localparam int SW = PIXEL_BITS + 4;

    // [row][channel], row 0 is the top line
    logic [2:0][2:0][PIXEL_BITS-1:0] r_w0;
    logic [2:0][2:0][PIXEL_BITS-1:0] r_w1;
    logic [2:0][2:0][PIXEL_BITS-1:0] cur;
    logic [2:0][SW-1:0]              sum;
    logic                            r_valid;
    logic [2:0][SW-1:0]              r_sum;
    rbb3_pkg::t_tag                  r_tag;

    assign cur[0] = i_top;
    assign cur[1] = i_mid;
    assign cur[2] = i_bot;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int rw = 0; rw < 3; rw++) begin
                sum[ch] = sum[ch] + SW'(r_w0[rw][ch]) + SW'(r_w1[rw][ch])
                        + SW'(cur[rw][ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_w0 <= '0;
            r_w1 <= '0;
        end else if (i_adv && i_valid) begin
            r_w0 <= r_w1;
            r_w1 <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid && i_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= sum;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_tag   = r_tag;

endmodule

### hdl/rbb3_mean.sv
// divide by nine in q8.8 and result register
`timescale 1ns / 1ps

module rbb3_mean #(
    parameter int PIXEL_BITS = rbb3_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [2:0][PIXEL_BITS+3:0]  i_sum,
    input  rbb3_pkg::t_tag              i_tag,
    output logic                        o_adv,
    rbb3_mean_if.source                 o_res
);

    localparam int SW = PIXEL_BITS + 4;
    localparam int XW = SW + 8;
    localparam int K  = XW + 4;
    localparam int MW = K - 2;
    localparam int PW = XW + MW;
    localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'd8) / 64'd9;
    localparam logic [MW-1:0] RECIP = RECIP_L[MW-1:0];

    logic [2:0][XW-1:0]                  num;
    logic [2:0][PW-1:0]                  prod;
    logic [2:0][rbb3_pkg::MEAN_W-1:0]    r_mean;
    rbb3_pkg::t_tag                      r_tag;
    logic                                r_valid;
    logic                                adv;

    // floor(x / 9) as (x * ceil(2^K / 9)) >> K, exact over the full x range
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            num[ch]  = {i_sum[ch], 8'd0} + XW'(4);
            prod[ch] = PW'(num[ch]) * PW'(RECIP);
        end
    end

    assign adv = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_mean[ch] <= rbb3_pkg::MEAN_W'(prod[ch] >> K);
            end
            r_tag <= i_tag;
        end
    end

    assign o_adv               = adv;
    assign o_res.valid         = r_valid;
    assign o_res.red_mean      = r_mean[0];
    assign o_res.green_mean    = r_mean[1];
    assign o_res.blue_mean     = r_mean[2];
    assign o_res.center_line   = r_tag.center_line;
    assign o_res.center_column = r_tag.center_column;
    assign o_res.frame_end     = r_tag.frame_end;

endmodule

### hdl/rgb_box_blur_3x3.sv
// top level of the rgb 3x3 box blur
`timescale 1ns / 1ps

// usage
// - i_pix takes one rgb pixel per request, raster order, line after line
// - o_mean gives one q8.8 mean per channel for each interior window centre,
//   tagged with centre line and column; frame_end marks the last of a frame
// - border pixels are taken but give no result
// - i_cfg_we with i_cfg_idx 0 sets line_length, 1 sets line_count; either
//   write restarts the frame (positions and window cleared), line stores kept
// - write configuration only while no request is in flight
// - pipeline: each pixel request passes the input stage with line store read,
//   then the sum stage, then the divide and result register
// - throughput: one pixel per cycle while the receiver does not stall; the
//   line store has one read and one write port and each pixel uses one of each
// - receiver stall: the result register holds and i_pix.ready drops, so
//   the whole pipe freezes until o_mean.ready returns
// - reset: positions, window and valid bits cleared, registers back to 600
//   pixels and 800 lines; line store contents undefined until written
module rgb_box_blur_3x3 #(
    parameter int MAX_LINE_LENGTH = rbb3_pkg::MAX_LINE_LENGTH_DEF,
    parameter int PIXEL_BITS      = rbb3_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbb3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbb3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rbb3_pix_if.sink                          i_pix,
    rbb3_mean_if.source                       o_mean
);

    localparam int CW = $clog2(MAX_LINE_LENGTH);
    localparam int LW = $clog2(MAX_LINE_LENGTH + 1);
    localparam int P3 = 3 * PIXEL_BITS;

    // configuration
    logic [rbb3_pkg::LEN_W-1:0] r_len;
    logic [rbb3_pkg::CNT_W-1:0] r_cnt;
    logic                       restart;
    logic [LW-1:0]              eff_len;
    logic [rbb3_pkg::CNT_W-1:0] eff_cnt;

    // positions of the next pixel
    logic [CW-1:0]                r_col;
    logic [rbb3_pkg::CNT_W-1:0]   r_line;
    logic [CW-1:0]                n_col;
    logic [rbb3_pkg::CNT_W-1:0]   n_line;
    logic [LW-1:0]                col_inc;
    logic [rbb3_pkg::CNT_W:0]     line_inc;

    // handshake
    logic adv;
    logic accept;

    // input stage
    logic                         r_a_valid;
    logic [2:0][PIXEL_BITS-1:0]   r_a_pix;
    logic                         r_a_prod;
    rbb3_pkg::t_tag               r_a_tag;
    rbb3_pkg::t_tag               a_tag_in;
    logic [CW-1:0]                r_a_col;
    logic [CW-1:0]                col_m1;

    // line store
    logic [2*P3-1:0]              rdata;
    logic [2:0][PIXEL_BITS-1:0]   top_row;
    logic [2:0][PIXEL_BITS-1:0]   mid_row;

    // sum stage
    logic                         b_valid;
    logic [2:0][PIXEL_BITS+3:0]   b_sum;
    rbb3_pkg::t_tag               b_tag;

    assign restart = i_cfg_we && (i_cfg_idx == rbb3_pkg::REG_LINE_LENGTH
                                  || i_cfg_idx == rbb3_pkg::REG_LINE_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= rbb3_pkg::LEN_RESET;
            r_cnt <= rbb3_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbb3_pkg::REG_LINE_LENGTH: r_len <= i_cfg_data[rbb3_pkg::LEN_W-1:0];
                rbb3_pkg::REG_LINE_COUNT:  r_cnt <= i_cfg_data[rbb3_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp line length to 3..max, line count to at least 3
    always_comb begin
        if (r_len < 11'd3) begin
            eff_len = LW'(3);
        end else if (32'(r_len) > MAX_LINE_LENGTH) begin
            eff_len = LW'(MAX_LINE_LENGTH);
        end else begin
            eff_len = LW'(r_len);
        end
        eff_cnt = (r_cnt < 16'd3) ? 16'd3 : r_cnt;
    end

    // the pipe moves whenever the result register can take a new value
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;

    // raster position update
    always_comb begin
        col_inc  = LW'(r_col) + 1'b1;
        line_inc = {1'b0, r_line} + 1'b1;
        n_col    = r_col;
        n_line   = r_line;
        if (col_inc >= eff_len) begin
            n_col = '0;
            if (line_inc >= {1'b0, eff_cnt}) begin
                n_line = '0;
            end else begin
                n_line = line_inc[rbb3_pkg::CNT_W-1:0];
            end
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    // tag of the window centred one line up and one column left
    assign col_m1                  = r_col - 1'b1;
    assign a_tag_in.center_line    = r_line - 1'b1;
    assign a_tag_in.center_column  = rbb3_pkg::CCOL_W'(col_m1);
    assign a_tag_in.frame_end      = (r_line == eff_cnt - 1'b1)
                                     && (LW'(r_col) == eff_len - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix  <= {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
            r_a_prod <= (r_line >= 16'd2) && (r_col >= CW'(2));
            r_a_tag  <= a_tag_in;
            r_a_col  <= r_col;
        end
    end

    // one word per column: upper half the line above, lower half two above;
    // read at request, written back as the pixel leaves the input stage
    rbb3_line_ram #(
        .DEPTH (MAX_LINE_LENGTH),
        .WIDTH (2 * P3)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata ({r_a_pix, mid_row}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    assign mid_row = rdata[2*P3-1:P3];
    assign top_row = rdata[P3-1:0];

    rbb3_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart),
        .i_adv   (adv),
        .i_valid (r_a_valid),
        .i_prod  (r_a_prod),
        .i_tag   (r_a_tag),
        .i_top   (top_row),
        .i_mid   (mid_row),
        .i_bot   (r_a_pix),
        .o_valid (b_valid),
        .o_sum   (b_sum),
        .o_tag   (b_tag)
    );

    rbb3_mean #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .i_sum   (b_sum),
        .i_tag   (b_tag),
        .o_adv   (adv),
        .o_res   (o_mean)
    );

    // positions stay inside the frame
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_col) < eff_len) && (r_line < eff_cnt))
        else $error("raster position outside frame");

    // a register write puts the next pixel at the frame origin
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_col == '0) && (r_line == '0))
        else $error("frame not restarted after register write");

    // results never come from centre line 0, the top border line
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mean.valid |-> (o_mean.center_line != '0))
        else $error("result from a border line");

    // the sum stage only fills from an occupied input stage
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_a_valid) |=> !b_valid)
        else $error("sum stage filled without a request");

endmodule
